[rtl/montgomery_modular_exponentiation_top_defines.svh]
// ----------------------------------------------------------------------------
// Montgomery exponentiation assertion macros
// Assertion helpers for the exponentiation block. They compile to nothing
// when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef MONTGOMERY_MODULAR_EXPONENTIATION_TOP_DEFINES_SVH
`define MONTGOMERY_MODULAR_EXPONENTIATION_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset
`define MME_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Condition must never be true outside reset
`define MME_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`else

`define MME_ASSERT(lbl, clk, rst_n, prop, msg)
`define MME_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

[rtl/mme_pkg.sv]
// ----------------------------------------------------------------------------
// mme_pkg
// Types shared by the exponentiation controller, the cell row and the cells.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mme_pkg;

    // Operation strobes for the cell row, one at most per cycle
    typedef struct packed {
        logic clear;   // accumulator to zero
        logic step;    // one radix-2 Montgomery iteration
        logic fix;     // final conditional subtract of the modulus
    } mme_ctl_t;

    // Link from one cell to the next higher cell
    typedef struct packed {
        logic [1:0] carry;   // add carry, 0..2
        logic       borrow;  // subtract borrow
    } mme_link_t;

endpackage

`default_nettype wire

[rtl/mme_cell.sv]
// ----------------------------------------------------------------------------
// mme_cell
// One bit of the Montgomery accumulator: adds its share of b and the modulus,
// passes its sum bit down for the halving shift, and holds one subtract stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mme_cell (
    input  wire                      aclk,
    input  wire mme_pkg::mme_ctl_t   ctl,
    input  wire                      ai,        // current multiplier bit
    input  wire                      q,         // reduction bit from the low cell
    input  wire                      ge,        // accumulator >= modulus
    input  wire                      b_bit,
    input  wire                      md_bit,
    input  wire mme_pkg::mme_link_t  link_in,   // from lower neighbor
    output mme_pkg::mme_link_t       link_out,  // to upper neighbor
    input  wire                      hi_sum,    // sum bit of upper neighbor
    output logic                     sum_bit,
    output logic                     acc_bit
);

    logic       acc_reg;
    logic       acc_next;
    logic [2:0] total;
    logic       diff;

    // Bit-level add: acc + ai*b + q*md + carry in
    assign total = {2'b00, acc_reg} + {2'b00, ai & b_bit} + {2'b00, q & md_bit}
                 + {1'b0, link_in.carry};
    assign sum_bit        = total[0];
    assign link_out.carry = total[2:1];

    // Bit-level subtract of the modulus
    assign diff            = acc_reg ^ md_bit ^ link_in.borrow;
    assign link_out.borrow = (~acc_reg & md_bit) | (~(acc_reg ^ md_bit) & link_in.borrow);

    // Next accumulator bit
    always_comb begin
        acc_next = acc_reg;
        if (ctl.clear) begin
            acc_next = 1'b0;
        end else if (ctl.step) begin
            acc_next = hi_sum;
        end else if (ctl.fix) begin
            acc_next = ge ? diff : acc_reg;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
    end

    assign acc_bit = acc_reg;

endmodule

`default_nettype wire

[rtl/mme_row.sv]
// ----------------------------------------------------------------------------
// mme_row
// Row of WIDTH+2 accumulator cells forming a bit-serial radix-2 Montgomery
// multiplier. Each step adds ai*b and q*M and halves; fix subtracts M once.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mme_row #(
    parameter int WIDTH = 32
) (
    input  wire                      aclk,
    input  wire mme_pkg::mme_ctl_t   ctl,
    input  wire                      ai,
    input  wire [WIDTH-1:0]          b,
    input  wire [WIDTH-1:0]          md,
    output logic [WIDTH+1:0]         acc
);

    localparam int N = WIDTH + 2;

    logic [N-1:0]       b_ext;
    logic [N-1:0]       md_ext;
    logic [N:0]         sum_w;
    mme_pkg::mme_link_t link_w [0:N];
    logic               q;
    logic               ge;

    assign b_ext  = {2'b00, b};
    assign md_ext = {2'b00, md};

    // Reduction bit makes the low sum bit zero
    assign q = acc[0] ^ (ai & b_ext[0]);

    // Chain ends
    assign link_w[0] = '0;
    assign sum_w[N]  = 1'b0;

    // No final borrow means acc >= M
    assign ge = ~link_w[N].borrow;

    for (genvar j = 0; j < N; j++) begin : g_cell
        mme_cell u_cell (
            .aclk     (aclk),
            .ctl      (ctl),
            .ai       (ai),
            .q        (q),
            .ge       (ge),
            .b_bit    (b_ext[j]),
            .md_bit   (md_ext[j]),
            .link_in  (link_w[j]),
            .link_out (link_w[j+1]),
            .hi_sum   (sum_w[j+1]),
            .sum_bit  (sum_w[j]),
            .acc_bit  (acc[j])
        );
    end

endmodule

`default_nettype wire

[rtl/montgomery_modular_exponentiation_top.sv]
// ----------------------------------------------------------------------------
// montgomery_modular_exponentiation_top
// Computes base^exponent mod M for each input word, M set over APB at offset 0
// (reset value 3). M must be odd and at least 3, else the result word is 0
// with tuser set. One word is worked on at a time; a new one is taken while
// the previous result waits on the output. With m the bit length of M, the
// cell row does one Montgomery iteration per cycle, m per multiply, with
// load, subtract and hand-off states around each multiply.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "montgomery_modular_exponentiation_top_defines.svh"

module montgomery_modular_exponentiation_top #(
    parameter int WIDTH = 32
) (
    input  wire         aclk,
    input  wire         aresetn,
    // input words
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire [63:0]  s_tdata,   // [31:0] base, [63:32] exponent
    // result words
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [31:0] m_tdata,   // [31:0] result
    output logic        m_tuser,   // [0] bad_modulus
    // configuration
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire [2:0]   paddr,
    input  wire [31:0]  pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CW = $clog2(WIDTH);
    localparam int LW = $clog2(WIDTH + 1);
    localparam int W1 = WIDTH + 1;

    localparam logic        REG_MODULUS   = 1'b0;
    localparam logic [31:0] MODULUS_RESET = 32'd3;

    typedef enum logic [3:0] {
        ST_IDLE, ST_LEN, ST_RED, ST_R2, ST_LOAD, ST_MM, ST_FIX, ST_NEXT, ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        OP_IN, OP_MUL, OP_SQ, OP_OUT
    } op_t;

    // Configuration register
    logic [31:0] modulus_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_MODULUS);
    assign prdata = (paddr[2] == REG_MODULUS) ? modulus_reg : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            modulus_reg <= MODULUS_RESET;
        end else if (cfg_wr) begin
            modulus_reg <= pwdata;
        end
    end

    // Working modulus and its checks
    logic [WIDTH-1:0] mdw;
    logic             bad_mod;

    assign mdw     = WIDTH'(modulus_reg);
    assign bad_mod = (mdw < WIDTH'(3)) || !mdw[0];

    // Sequencer registers
    state_t           state_reg,   state_next;
    op_t              op_reg,      op_next;
    logic [CW-1:0]    cnt_reg,     cnt_next;
    logic [LW-1:0]    mlen_reg,    mlen_next;
    logic [WIDTH-1:0] base_sh_reg, base_sh_next;
    logic [WIDTH-1:0] exp_reg,     exp_next;
    logic [WIDTH-1:0] dbl_reg,     dbl_next;
    logic [WIDTH-1:0] sq_reg,      sq_next;
    logic [WIDTH-1:0] pacc_reg,    pacc_next;
    logic [WIDTH-1:0] a_sh_reg,    a_sh_next;
    logic [WIDTH-1:0] b_reg,       b_next;
    logic [WIDTH-1:0] out_res_reg, out_res_next;
    logic             out_bad_reg, out_bad_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [WIDTH-1:0] m_res_reg,   m_res_next;
    logic             m_bad_reg,   m_bad_next;

    // Shared modular doubler: {dbl, bit} mod M
    logic             dbl_bit;
    logic [W1-1:0]    dbl_t;
    logic [W1-1:0]    md_x;
    logic [WIDTH-1:0] dbl_step;

    assign dbl_bit  = (state_reg == ST_RED) ? base_sh_reg[WIDTH-1] : 1'b0;
    assign dbl_t    = {dbl_reg, dbl_bit};
    assign md_x     = {1'b0, mdw};
    assign dbl_step = WIDTH'((dbl_t >= md_x) ? (dbl_t - md_x) : dbl_t);

    // R mod M = 2^m - M
    logic [W1-1:0]    r_pow;
    logic [WIDTH-1:0] r1;

    assign r_pow = W1'(1) << mlen_reg;
    assign r1    = WIDTH'(r_pow - md_x);

    // Cell row
    mme_pkg::mme_ctl_t ctl;
    logic [WIDTH+1:0]  row_acc;

    assign ctl.clear = (state_reg == ST_LOAD);
    assign ctl.step  = (state_reg == ST_MM);
    assign ctl.fix   = (state_reg == ST_FIX);

    mme_row #(
        .WIDTH (WIDTH)
    ) u_row (
        .aclk (aclk),
        .ctl  (ctl),
        .ai   (a_sh_reg[0]),
        .b    (b_reg),
        .md   (mdw),
        .acc  (row_acc)
    );

    // Next-state logic
    always_comb begin
        logic             mm_go;
        op_t              mm_op;
        logic [WIDTH-1:0] mm_a;
        logic [WIDTH-1:0] mm_b;
        logic             chk;
        logic [WIDTH-1:0] e_v;
        logic [WIDTH-1:0] sq_v;
        logic [WIDTH-1:0] res_v;

        state_next    = state_reg;
        op_next       = op_reg;
        cnt_next      = cnt_reg;
        mlen_next     = mlen_reg;
        base_sh_next  = base_sh_reg;
        exp_next      = exp_reg;
        dbl_next      = dbl_reg;
        sq_next       = sq_reg;
        pacc_next     = pacc_reg;
        a_sh_next     = a_sh_reg;
        b_next        = b_reg;
        out_res_next  = out_res_reg;
        out_bad_next  = out_bad_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_res_next    = m_res_reg;
        m_bad_next    = m_bad_reg;

        mm_go = 1'b0;
        mm_op = OP_IN;
        mm_a  = '0;
        mm_b  = '0;
        chk   = 1'b0;
        e_v   = exp_reg;
        sq_v  = sq_reg;
        res_v = WIDTH'(row_acc);

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    base_sh_next = WIDTH'(s_tdata[31:0]);
                    exp_next     = WIDTH'(s_tdata[63:32]);
                    if (bad_mod) begin
                        out_res_next = '0;
                        out_bad_next = 1'b1;
                        state_next   = ST_OUT;
                    end else begin
                        cnt_next   = CW'(WIDTH - 1);
                        state_next = ST_LEN;
                    end
                end
            end
            // scan down for the top set bit of M
            ST_LEN: begin
                if (mdw[cnt_reg]) begin
                    mlen_next  = LW'(cnt_reg) + LW'(1);
                    dbl_next   = '0;
                    cnt_next   = CW'(WIDTH - 1);
                    state_next = ST_RED;
                end else begin
                    cnt_next = cnt_reg - CW'(1);
                end
            end
            // base mod M, one base bit per cycle from the top
            ST_RED: begin
                dbl_next     = dbl_step;
                base_sh_next = base_sh_reg << 1;
                if (cnt_reg == '0) begin
                    sq_next    = dbl_step;
                    dbl_next   = r1;
                    pacc_next  = r1;
                    cnt_next   = CW'(mlen_reg - LW'(1));
                    state_next = ST_R2;
                end else begin
                    cnt_next = cnt_reg - CW'(1);
                end
            end
            // R^2 mod M by m doublings of R mod M
            ST_R2: begin
                dbl_next = dbl_step;
                if (cnt_reg == '0) begin
                    mm_go = 1'b1;
                    mm_op = OP_IN;
                    mm_a  = sq_reg;
                    mm_b  = dbl_step;
                end else begin
                    cnt_next = cnt_reg - CW'(1);
                end
            end
            ST_LOAD: begin
                state_next = ST_MM;
            end
            ST_MM: begin
                a_sh_next = a_sh_reg >> 1;
                if (cnt_reg == '0) begin
                    state_next = ST_FIX;
                end else begin
                    cnt_next = cnt_reg - CW'(1);
                end
            end
            ST_FIX: begin
                state_next = ST_NEXT;
            end
            // take the product and pick the next multiply
            ST_NEXT: begin
                case (op_reg)
                    OP_IN: begin
                        sq_next = res_v;
                        sq_v    = res_v;
                        chk     = 1'b1;
                    end
                    OP_SQ: begin
                        sq_next  = res_v;
                        sq_v     = res_v;
                        exp_next = exp_reg >> 1;
                        e_v      = exp_reg >> 1;
                        chk      = 1'b1;
                    end
                    OP_MUL: begin
                        pacc_next = res_v;
                        mm_go     = 1'b1;
                        mm_op     = OP_SQ;
                        mm_a      = sq_reg;
                        mm_b      = sq_reg;
                    end
                    OP_OUT: begin
                        out_res_next = res_v;
                        out_bad_next = 1'b0;
                        state_next   = ST_OUT;
                    end
                    default: begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_res_next    = out_res_reg;
                    m_bad_next    = out_bad_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // exponent bit scan, low bit first
        if (chk) begin
            mm_go = 1'b1;
            if (e_v == '0) begin
                mm_op = OP_OUT;
                mm_a  = pacc_reg;
                mm_b  = WIDTH'(1);
            end else if (e_v[0]) begin
                mm_op = OP_MUL;
                mm_a  = sq_v;
                mm_b  = pacc_reg;
            end else begin
                mm_op = OP_SQ;
                mm_a  = sq_v;
                mm_b  = sq_v;
            end
        end

        // launch a multiply on the cell row
        if (mm_go) begin
            a_sh_next  = mm_a;
            b_next     = mm_b;
            op_next    = mm_op;
            cnt_next   = CW'(mlen_reg - LW'(1));
            state_next = ST_LOAD;
        end
    end

    // State and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            op_reg       <= op_next;
            cnt_reg      <= cnt_next;
            mlen_reg     <= mlen_next;
            base_sh_reg  <= base_sh_next;
            exp_reg      <= exp_next;
            dbl_reg      <= dbl_next;
            sq_reg       <= sq_next;
            pacc_reg     <= pacc_next;
            a_sh_reg     <= a_sh_next;
            b_reg        <= b_next;
            out_res_reg  <= out_res_next;
            out_bad_reg  <= out_bad_next;
            m_res_reg    <= m_res_next;
            m_bad_reg    <= m_bad_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = 32'(m_res_reg);
    assign m_tuser  = m_bad_reg;

    // Checks
    `MME_ASSERT(a_bad_zero, aclk, aresetn, (m_tvalid_reg && m_bad_reg) |-> (m_res_reg == '0), "bad modulus word carries nonzero result")
    `MME_ASSERT_NEVER(a_res_range, aclk, aresetn, m_tvalid_reg && !m_bad_reg && (m_res_reg >= mdw), "result not reduced below modulus")
    `MME_ASSERT(a_one_item, aclk, aresetn, (s_tvalid && s_tready) |=> !s_tready, "second word taken while busy")
    `MME_ASSERT(a_prod_range, aclk, aresetn, (state_reg == ST_NEXT) |-> (row_acc < {2'b00, mdw}), "Montgomery product not below modulus")
    `MME_ASSERT(a_mm_run, aclk, aresetn, (state_reg == ST_MM && cnt_reg != '0) |=> (state_reg == ST_MM), "multiply left before its last iteration")

endmodule

`default_nettype wire
